/* design/cdas_pkg.sv */
package cdas_pkg;

  // Reset values of the configuration registers.
  localparam logic [8:0] TOTAL_RESET    = 9'd92;
  localparam logic [8:0] RESERVED_RESET = 9'd2;

  // User byte codes that mark a directory entry as deleted.
  localparam logic [7:0] USER_DEL_E5 = 8'hE5;
  localparam logic [7:0] USER_DEL_47 = 8'h47;
  localparam logic [7:0] USER_DEL_4C = 8'h4C;

  // Byte positions inside a 32-byte entry.
  localparam logic [4:0] POS_USER      = 5'd0;
  localparam logic [4:0] POS_RO        = 5'd9;
  localparam logic [4:0] POS_SYS       = 5'd10;
  localparam logic [4:0] POS_ARC       = 5'd11;
  localparam logic [4:0] POS_XL        = 5'd12;
  localparam logic [4:0] POS_BC        = 5'd13;
  localparam logic [4:0] POS_XH        = 5'd14;
  localparam logic [4:0] POS_RC        = 5'd15;
  localparam logic [4:0] POS_ALLOC     = 5'd16;
  localparam logic [4:0] POS_LAST      = 5'd31;

  // Configuration register indexes.
  typedef enum logic {
    CFG_TOTAL    = 1'b0,
    CFG_RESERVED = 1'b1
  } cdas_cfg_idx_t;

  // Work the back end does for one queued command.
  typedef enum logic [1:0] {
    OP_SKIP  = 2'd0,
    OP_FIRST = 2'd1,
    OP_ALLOC = 2'd2,
    OP_START = 2'd3
  } cdas_op_t;

  typedef struct packed {
    logic       action;
    logic [7:0] dir_byte;
  } cdas_in_t;

  typedef struct packed {
    logic        deleted;
    logic [7:0]  user_number;
    logic        read_only;
    logic        system_file;
    logic        archived;
    logic [12:0] extent;
    logic [7:0]  record_count;
    logic [7:0]  last_record_bytes;
    logic [8:0]  free_blocks;
    logic        other_user_seen;
    logic        block_out_of_range;
  } cdas_out_t;

  // Command passed from the front end to the back end. The summary is
  // meaningful only on the last byte of an entry; the back end fills in
  // the free count and the range flag.
  typedef struct packed {
    cdas_op_t   op;
    logic [7:0] blk;
    logic       last;
    cdas_out_t  summary;
  } cdas_cmd_t;

  function automatic logic is_deleted(input logic [7:0] u);
    return (u == USER_DEL_E5) || (u == USER_DEL_47) || (u == USER_DEL_4C);
  endfunction

endpackage

/* design/cpm_directory_alloc_scanner_top.sv */
// Channel         Direction  Handshake            Payload
// dir_item        in         push / full          cdas_in_t (action, dir_byte)
// entry_result    out        pop / empty          cdas_out_t, one per 32-byte entry
// configuration   in         cfg_we (no wait)     cfg_index, cfg_data
//
// One directory byte is taken every clock cycle while the command queue has room; the
// front end classifies it in the cycle it arrives, and the back end updates the allocation
// map one command per cycle unless a finished entry waits on a full result queue.
// The map word is read as a command leaves the queue; the compare and free-count update
// follow in the next stage, with a word just written passed straight to a read of it.
// Reset is synchronous; it loads 92 total and 2 reserved blocks and clears the map.
// The input stalls only when the command queue fills, which happens only while the
// result queue is full and a finished entry waits to be written into it.
module cpm_directory_alloc_scanner_top
  import cdas_pkg::*;
  #(parameter int MAX_BLOCKS = 256,
    parameter int CMD_DEPTH  = 2)
  (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cdas_in_t   dir_item,
  output logic       full,
  input  logic       pop,
  output cdas_out_t  entry_result,
  output logic       empty,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  // Configuration registers. Range checks use the current total; the map
  // layout is taken from them only when a start command reaches the back end.
  logic [8:0] total_blocks;
  logic [8:0] reserved_blocks;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks    <= TOTAL_RESET;
      reserved_blocks <= RESERVED_RESET;
    end else if (cfg_we) begin
      unique case (cdas_cfg_idx_t'(cfg_index))
        CFG_TOTAL:    total_blocks    <= cfg_data;
        CFG_RESERVED: reserved_blocks <= cfg_data;
        default: ;
      endcase
    end
  end

  logic      accept;
  logic      cmd_push;
  logic      cmd_full;
  cdas_cmd_t cmd_in;
  logic      cmd_pop;
  logic      cmd_empty;
  cdas_cmd_t cmd_head;
  logic      res_push;
  logic      res_full;
  cdas_out_t res_in;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // The front end owns the byte position and the captured entry fields.
  cdas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (dir_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  cdas_fifo #(
    .WIDTH ($bits(cdas_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  // The back end owns the allocation map, the free count and the range flag.
  cdas_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .total_blocks    (total_blocks),
    .reserved_blocks (reserved_blocks),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd_head),
    .cmd_pop         (cmd_pop),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (res_in)
  );

  // Output queue: a finished item waits here while new bytes keep flowing.
  cdas_fifo #(
    .WIDTH ($bits(cdas_out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (entry_result),
    .empty   (empty)
  );

  // The back end never pushes into a full result queue.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // The front end never pushes into a full command queue.
  a_no_cmd_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  // The free count never exceeds the largest map.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_in.free_blocks <= 9'd256))
    else $error("free count out of bounds");

  // Reset leaves no stale item in the result queue.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

/* design/cdas_fifo.sv */
module cdas_fifo
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 2)
  (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/cdas_front.sv */
module cdas_front
  import cdas_pkg::*;
  (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cdas_in_t  item,
  output logic      cmd_push,
  output cdas_cmd_t cmd
);

  logic [4:0] pos;
  logic [7:0] user;
  logic [2:0] flags;
  logic [4:0] xl;
  logic [7:0] bc;
  logic [7:0] xh;
  logic [7:0] rc;
  logic       nz_user;

  logic [7:0] user_eff;
  logic       dead;
  logic [2:0] flags_next;
  logic       nz_next;
  logic [7:0] b;

  assign b = item.dir_byte;

  always_comb begin
    user_eff   = (pos == POS_USER) ? b : user;
    dead       = is_deleted(user_eff);
    flags_next = (pos == POS_USER) ? 3'b000 : flags;
    if (pos == POS_RO)  flags_next[0] = flags_next[0] | b[7];
    if (pos == POS_SYS) flags_next[1] = flags_next[1] | b[7];
    if (pos == POS_ARC) flags_next[2] = flags_next[2] | b[7];
    nz_next = nz_user || ((pos == POS_USER) && !is_deleted(b) && (b != 8'd0));
  end

  // Classify the byte for the back end.
  always_comb begin
    cmd          = '0;
    cmd.blk      = b;
    cmd.last     = 1'b0;
    if (item.action) begin
      cmd.op = OP_START;
    end else begin
      priority if (pos == POS_USER) begin
        cmd.op = OP_FIRST;
      end else if ((pos >= POS_ALLOC) && !dead && (b != 8'd0)) begin
        cmd.op = OP_ALLOC;
      end else begin
        cmd.op = OP_SKIP;
      end
      cmd.last = (pos == POS_LAST);
    end
    cmd.summary.deleted         = dead;
    cmd.summary.user_number     = user_eff;
    cmd.summary.other_user_seen = nz_next;
    if (!dead) begin
      cmd.summary.read_only         = flags_next[0];
      cmd.summary.system_file       = flags_next[1];
      cmd.summary.archived          = flags_next[2];
      cmd.summary.extent            = {xh, xl};
      cmd.summary.record_count      = rc;
      cmd.summary.last_record_bytes = bc;
    end
  end

  assign cmd_push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      nz_user <= 1'b0;
      user    <= '0;
      flags   <= '0;
    end else if (accept) begin
      if (item.action) begin
        pos     <= '0;
        nz_user <= 1'b0;
        user    <= '0;
        flags   <= '0;
      end else begin
        pos     <= pos + 1'b1;
        nz_user <= nz_next;
        user    <= user_eff;
        flags   <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !item.action) begin
      if (pos == POS_XL) xl <= b[4:0];
      if (pos == POS_BC) bc <= b;
      if (pos == POS_XH) xh <= b;
      if (pos == POS_RC) rc <= b;
    end
  end

endmodule

/* design/cdas_back.sv */
module cdas_back
  import cdas_pkg::*;
  #(parameter int MAX_BLOCKS = 256)
  (
  input  logic       clk,
  input  logic       rst,
  input  logic [8:0] total_blocks,
  input  logic [8:0] reserved_blocks,
  input  logic       cmd_empty,
  input  cdas_cmd_t  cmd,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output cdas_out_t  res
);

  localparam int         WORDS   = (MAX_BLOCKS + 7) / 8;
  localparam int         WAW     = $clog2(WORDS);
  localparam logic [8:0] MAX_TOT = 9'(MAX_BLOCKS);
  localparam int RST_TOT = (int'(TOTAL_RESET) > MAX_BLOCKS) ? MAX_BLOCKS : int'(TOTAL_RESET);
  localparam int RST_RES = (int'(RESERVED_RESET) > RST_TOT) ? RST_TOT : int'(RESERVED_RESET);

  // Allocation map, eight blocks to a word. A word whose valid bit is clear has
  // not been written since the last start and reads as all free.
  logic [7:0]       map_mem [WORDS];
  logic [WORDS-1:0] word_valid;
  logic [7:0]       map_q;

  // Execute stage: the command whose map word was read at the previous pop.
  logic             ex_valid;
  cdas_cmd_t        ex_cmd;

  // Last word written by the execute stage, for a read issued at the same edge.
  logic             wr_valid;
  logic [WAW-1:0]   wr_addr;
  logic [7:0]       wr_word;

  logic [8:0]       res_snap;
  logic [8:0]       free_count;
  logic             range_err;

  logic [8:0]     eff_tot;
  logic [8:0]     eff_res;
  logic [8:0]     blk9;
  logic [WAW-1:0] rd_addr;
  logic [WAW-1:0] ex_addr;
  logic [2:0]     ex_bit;
  logic [7:0]     cur_word;
  logic [7:0]     word_next;
  logic           in_range;
  logic           used;
  logic           do_mark;
  logic [8:0]     free_next;
  logic           range_next;
  logic           ex_fire;

  assign rd_addr = cmd.blk[WAW+2:3];
  assign ex_addr = ex_cmd.blk[WAW+2:3];
  assign ex_bit  = ex_cmd.blk[2:0];

  always_comb begin
    eff_tot  = (total_blocks > MAX_TOT) ? MAX_TOT : total_blocks;
    eff_res  = (reserved_blocks > eff_tot) ? eff_tot : reserved_blocks;
    blk9     = {1'b0, ex_cmd.blk};
    in_range = (blk9 < eff_tot);
    priority if (wr_valid && (wr_addr == ex_addr)) begin
      cur_word = wr_word;
    end else if (word_valid[ex_addr]) begin
      cur_word = map_q;
    end else begin
      cur_word = 8'd0;
    end
    // A block never marked since the last start reads as used only if reserved.
    used      = cur_word[ex_bit] || (blk9 < res_snap);
    word_next = cur_word | (8'd1 << ex_bit);
    do_mark   = 1'b0;
    free_next  = free_count;
    range_next = range_err;
    unique case (ex_cmd.op)
      OP_FIRST: range_next = 1'b0;
      OP_ALLOC: begin
        if (!in_range) begin
          range_next = 1'b1;
        end else if (!used) begin
          do_mark = 1'b1;
          if (free_count != 9'd0) begin
            free_next = free_count - 1'b1;
          end
        end
      end
      OP_START: begin
        range_next = 1'b0;
        free_next  = eff_tot - eff_res;
      end
      OP_SKIP: ;
      default: ;
    endcase
  end

  assign ex_fire  = ex_valid && !(ex_cmd.last && res_full);
  assign cmd_pop  = !cmd_empty && (!ex_valid || ex_fire);
  assign res_push = ex_fire && ex_cmd.last;

  always_comb begin
    res                    = ex_cmd.summary;
    res.free_blocks        = free_next;
    res.block_out_of_range = ex_cmd.summary.deleted ? 1'b0 : range_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid   <= 1'b0;
      ex_cmd     <= '0;
      wr_valid   <= 1'b0;
      word_valid <= '0;
      res_snap   <= 9'(RST_RES);
      free_count <= 9'(RST_TOT - RST_RES);
      range_err  <= 1'b0;
    end else begin
      if (cmd_pop) begin
        ex_valid <= 1'b1;
        ex_cmd   <= cmd;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        free_count <= free_next;
        range_err  <= range_next;
        wr_valid   <= do_mark;
        if (ex_cmd.op == OP_START) begin
          word_valid <= '0;
          res_snap   <= eff_res;
        end else if (do_mark) begin
          word_valid[ex_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      map_q <= map_mem[rd_addr];
    end
    if (ex_fire && do_mark) begin
      map_mem[ex_addr] <= word_next;
      wr_addr          <= ex_addr;
      wr_word          <= word_next;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cdas_pkg::*;

  // The block under test sees a directory as a plain byte stream. Every 32nd byte closes an
  // entry and should produce exactly one entry result. A start item rebuilds the allocation
  // map and produces nothing.
  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  cdas_in_t   dir_item = '0;
  logic       full;
  logic       pop = 1'b0;
  cdas_out_t  entry_result;
  logic       empty;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  cpm_directory_alloc_scanner_top DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .dir_item     (dir_item),
    .full         (full),
    .pop          (pop),
    .entry_result (entry_result),
    .empty        (empty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run should end well inside this time. If it has not, a result went missing or the
  // handshake hung.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL cpm_directory_alloc_scanner_top");
    $finish;
  end

  // ------------------------------------------------------------------------------------
  // Allocation map predictor. It keeps its own copy of the register settings, the block
  // map and the partly decoded entry, and queues one expected result per finished entry.
  // ------------------------------------------------------------------------------------
  logic [8:0] total_reg;
  logic [8:0] reserved_reg;
  bit         alloc_map [256];
  logic [4:0] entry_pos;
  logic [7:0] cur_user;
  logic [2:0] cur_flags;
  logic [7:0] cur_xl;
  logic [7:0] cur_bc;
  logic [7:0] cur_xh;
  logic [7:0] cur_rc;
  logic [8:0] free_left;
  logic       live_user_seen;
  logic       bad_block_seen;

  cdas_out_t  expected_entries [$];
  int         mismatches = 0;

  // Sender and receiver idling controls. An eager side never idles on its own.
  bit         tx_eager = 1'b0;
  bit         rx_eager = 1'b0;
  int         hold_cycles = 0;

  // One directory entry staged for sending.
  logic [7:0] entry_buf [32];

  // Both registers are clamped to the map size when they are used.
  function automatic int usable_blocks();
    return (total_reg > 9'd256) ? 256 : int'(total_reg);
  endfunction

  function automatic logic user_gone(logic [7:0] u);
    return (u == USER_DEL_E5) || (u == USER_DEL_47) || (u == USER_DEL_4C);
  endfunction

  // A fresh map has the leading reserved blocks in use, and the free count covers the
  // rest. Any partly received entry is dropped.
  function automatic void restart_map();
    int tot;
    int res;
    tot = usable_blocks();
    res = (int'(reserved_reg) > tot) ? tot : int'(reserved_reg);
    for (int i = 0; i < 256; i++) alloc_map[i] = (i < res);
    free_left      = 9'(tot - res);
    live_user_seen = 1'b0;
    bad_block_seen = 1'b0;
    entry_pos      = POS_USER;
    cur_user       = '0;
    cur_flags      = '0;
    cur_xl         = '0;
    cur_bc         = '0;
    cur_xh         = '0;
    cur_rc         = '0;
  endfunction

  function automatic void scan_dir_byte(cdas_in_t it);
    cdas_out_t  want;
    logic       dead;
    logic [7:0] b;
    b = it.dir_byte;
    if (it.action) begin
      restart_map();
      return;
    end
    if (entry_pos == POS_USER) begin
      cur_user       = b;
      cur_flags      = '0;
      bad_block_seen = 1'b0;
      if (!user_gone(b) && b != 8'd0) live_user_seen = 1'b1;
    end
    dead = user_gone(cur_user);
    if (entry_pos >= POS_RO && entry_pos <= POS_ARC) begin
      if (b[7]) cur_flags[entry_pos - POS_RO] = 1'b1;
    end else if (entry_pos == POS_XL) begin
      cur_xl = b;
    end else if (entry_pos == POS_BC) begin
      cur_bc = b;
    end else if (entry_pos == POS_XH) begin
      cur_xh = b;
    end else if (entry_pos == POS_RC) begin
      cur_rc = b;
    end else if (entry_pos >= POS_ALLOC && !dead && b != 8'd0) begin
      // Out-of-range blocks are flagged but never stored; a block that is already used
      // leaves the free count alone.
      if (int'(b) >= usable_blocks()) begin
        bad_block_seen = 1'b1;
      end else if (!alloc_map[b]) begin
        alloc_map[b] = 1'b1;
        if (free_left != 9'd0) free_left = free_left - 9'd1;
      end
    end
    if (entry_pos == POS_LAST) begin
      want             = '0;
      want.deleted     = dead;
      want.user_number = cur_user;
      if (!dead) begin
        want.read_only          = cur_flags[0];
        want.system_file        = cur_flags[1];
        want.archived           = cur_flags[2];
        want.extent             = {cur_xh, cur_xl[4:0]};
        want.record_count       = cur_rc;
        want.last_record_bytes  = cur_bc;
        want.block_out_of_range = bad_block_seen;
      end
      want.free_blocks     = free_left;
      want.other_user_seen = live_user_seen;
      expected_entries = {expected_entries, want};
    end
    entry_pos = entry_pos + 5'd1;
  endfunction

  // ------------------------------------------------------------------------------------
  // Result side. Each accepted entry result is compared field by field with the oldest
  // expected one.
  // ------------------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic take_result(cdas_out_t got);
    cdas_out_t want;
    if (expected_entries.size() == 0) begin
      mismatches++;
      $display("%0t ns: entry result with none outstanding, expected none, got %h",
               $time, got);
      return;
    end
    want = expected_entries.pop_front();
    check_field("deleted", want.deleted, got.deleted);
    check_field("user_number", want.user_number, got.user_number);
    check_field("read_only", want.read_only, got.read_only);
    check_field("system_file", want.system_file, got.system_file);
    check_field("archived", want.archived, got.archived);
    check_field("extent", want.extent, got.extent);
    check_field("record_count", want.record_count, got.record_count);
    check_field("last_record_bytes", want.last_record_bytes, got.last_record_bytes);
    check_field("free_blocks", want.free_blocks, got.free_blocks);
    check_field("other_user_seen", want.other_user_seen, got.other_user_seen);
    check_field("block_out_of_range", want.block_out_of_range, got.block_out_of_range);
  endtask

  // The receiver waits a randomly drawn gap before each result unless it is eager. A long
  // hold-off, when one is requested, is counted out here so that the sender keeps going.
  // Outputs are read right after the clock edge, so they still hold their pre-edge values.
  initial begin : result_drain
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = rx_eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      take_result(entry_result);
    end
  end

  // ------------------------------------------------------------------------------------
  // Sender side.
  // ------------------------------------------------------------------------------------

  // Offers one item and returns at the edge where it is taken. The predictor steps at
  // that edge. The last result shows only after its byte has passed the command queue, the
  // execute stage and the result queue, so the expectation is always queued first.
  task automatic send_item(logic act, logic [7:0] b);
    cdas_in_t it;
    int       gap;
    it.action   = act;
    it.dir_byte = b;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    dir_item <= it;
    do @(posedge clk); while (full);
    scan_dir_byte(it);
  endtask

  task automatic send_entry(int n = 32);
    for (int i = 0; i < n; i++) send_item(1'b0, entry_buf[i]);
  endtask

  // Stages an entry. The name bytes and the low bits of the flag bytes are random, and
  // the allocation bytes start out empty.
  task automatic fill_entry(logic [7:0] user, logic [2:0] flags, logic [7:0] xl,
                            logic [7:0] bc, logic [7:0] xh, logic [7:0] rc);
    entry_buf[0] = user;
    for (int i = 1; i <= 8; i++) entry_buf[i] = 8'($urandom);
    for (int i = 0; i < 3; i++) entry_buf[9 + i] = {flags[i], 7'($urandom)};
    entry_buf[12] = xl;
    entry_buf[13] = bc;
    entry_buf[14] = xh;
    entry_buf[15] = rc;
    for (int i = 16; i < 32; i++) entry_buf[i] = 8'd0;
  endtask

  // A random entry. Most users are zero or small, some are deleted markers. Most
  // allocation bytes name blocks inside the disk, the rest are empty or arbitrary.
  task automatic random_entry();
    logic [7:0] user;
    int         lim;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: user = 8'd0;
      8, 9, 10, 11:           user = 8'($urandom_range(1, 15));
      12:                     user = USER_DEL_E5;
      13:                     user = USER_DEL_47;
      14:                     user = USER_DEL_4C;
      default:                user = 8'($urandom);
    endcase
    fill_entry(user, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    lim = usable_blocks();
    for (int i = 16; i < 32; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: entry_buf[i] = 8'd0;
        6, 7, 8:          entry_buf[i] = 8'($urandom);
        default:          entry_buf[i] = (lim > 1) ? 8'($urandom_range(1, lim - 1))
                                                   : 8'($urandom);
      endcase
    end
  endtask

  // Registers may only change while the block is idle, so the sender stops, every
  // outstanding result is collected, and the back end gets time to finish any bytes
  // that produce no result.
  task automatic settle_block();
    push <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes one register and then leaves the write enable low before returning.
  task automatic write_reg(cdas_cfg_idx_t idx, logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TOTAL:    total_reg = val;
      CFG_RESERVED: reserved_reg = val;
      default:      ;
    endcase
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------------------------
  // Tests.
  // ------------------------------------------------------------------------------------

  // Hand-built entries under the reset settings: full-scale fields, every deleted marker,
  // repeated, reserved, empty and out-of-range blocks, and a start that cuts into an entry.
  task automatic test_directed_entries();
    // All fields at their maximum. Block 1 is reserved, 3 appears twice, and 92 and 255
    // lie beyond the disk.
    fill_entry(8'h00, 3'b111, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    entry_buf[16] = 8'd1;
    entry_buf[17] = 8'd2;
    entry_buf[18] = 8'd3;
    entry_buf[19] = 8'd91;
    entry_buf[20] = 8'd92;
    entry_buf[21] = 8'hFF;
    entry_buf[22] = 8'd3;
    send_entry();

    // A live entry with a nonzero user and every field at zero.
    fill_entry(8'h0F, 3'b000, 8'h00, 8'h00, 8'h00, 8'h00);
    entry_buf[31] = 8'd4;
    send_entry();

    // Deleted entries claim blocks and carry flags, and all of it must be ignored.
    fill_entry(USER_DEL_E5, 3'b111, 8'hFF, 8'h12, 8'h34, 8'h56);
    entry_buf[16] = 8'd10;
    entry_buf[17] = 8'd11;
    entry_buf[18] = 8'd200;
    send_entry();
    fill_entry(USER_DEL_47, 3'b101, 8'h3F, 8'h80, 8'h01, 8'h7F);
    entry_buf[20] = 8'd12;
    send_entry();
    fill_entry(USER_DEL_4C, 3'b010, 8'h1F, 8'h01, 8'hFE, 8'h02);
    entry_buf[31] = 8'd13;
    send_entry();

    // One flag at a time, each entry filling all sixteen allocation slots.
    fill_entry(8'h1F, 3'b001, 8'h01, 8'h80, 8'h00, 8'h80);
    for (int i = 16; i < 32; i++) entry_buf[i] = 8'(i + 4);
    send_entry();
    fill_entry(8'hFF, 3'b010, 8'h20, 8'h7F, 8'h80, 8'h01);
    for (int i = 16; i < 32; i++) entry_buf[i] = 8'(i + 20);
    send_entry();
    fill_entry(8'hE4, 3'b100, 8'hC5, 8'h40, 8'h7F, 8'h10);
    for (int i = 16; i < 32; i++) entry_buf[i] = 8'(i + 60);
    send_entry();

    // A start in the middle of an entry drops it and clears the nonzero user flag. The
    // entry after it has an extent of exactly 32.
    fill_entry(8'h05, 3'b111, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_entry(10);
    send_item(1'b1, 8'hFF);
    fill_entry(8'h00, 3'b000, 8'hE0, 8'h80, 8'h01, 8'h80);
    entry_buf[16] = 8'd5;
    send_entry();
  endtask

  // Register extremes, including a zero total and values past the map size, plus range
  // changes made without a start so that the old map layout stays in place.
  task automatic test_register_extremes();
    settle_block();
    write_reg(CFG_TOTAL, 9'd256);
    write_reg(CFG_RESERVED, 9'd0);
    send_item(1'b1, 8'($urandom));
    fill_entry(8'h02, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    entry_buf[16] = 8'hFF;
    entry_buf[17] = 8'h80;
    entry_buf[18] = 8'hFF;
    send_entry();

    // Reserved larger than total: the whole one-block disk is reserved.
    settle_block();
    write_reg(CFG_TOTAL, 9'd1);
    write_reg(CFG_RESERVED, 9'd256);
    send_item(1'b1, 8'($urandom));
    fill_entry(8'h00, 3'b000, 8'h00, 8'h00, 8'h00, 8'h00);
    entry_buf[16] = 8'd1;
    send_entry();

    // With a total of zero every nonzero block is out of range.
    settle_block();
    write_reg(CFG_TOTAL, 9'd0);
    write_reg(CFG_RESERVED, 9'd0);
    send_item(1'b1, 8'($urandom));
    fill_entry(8'h03, 3'b111, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    entry_buf[16] = 8'd1;
    entry_buf[31] = 8'hFF;
    send_entry();

    settle_block();
    write_reg(CFG_TOTAL, 9'd511);
    write_reg(CFG_RESERVED, 9'd511);
    send_item(1'b1, 8'($urandom));
    fill_entry(8'h00, 3'b000, 8'h00, 8'h00, 8'h00, 8'h00);
    entry_buf[16] = 8'hFF;
    entry_buf[17] = 8'd0;
    send_entry();

    settle_block();
    write_reg(CFG_TOTAL, 9'd16);
    write_reg(CFG_RESERVED, 9'd3);
    send_item(1'b1, 8'($urandom));
    fill_entry(8'h00, 3'b000, 8'h00, 8'h00, 8'h00, 8'h00);
    entry_buf[16] = 8'd5;
    entry_buf[17] = 8'd16;
    send_entry();

    // Raising and then lowering the total without a start.
    settle_block();
    write_reg(CFG_TOTAL, 9'd100);
    fill_entry(8'h00, 3'b000, 8'h00, 8'h00, 8'h00, 8'h00);
    entry_buf[16] = 8'd50;
    entry_buf[17] = 8'd15;
    send_entry();
    settle_block();
    write_reg(CFG_TOTAL, 9'd8);
    fill_entry(8'h00, 3'b000, 8'h00, 8'h00, 8'h00, 8'h00);
    entry_buf[16] = 8'd10;
    entry_buf[17] = 8'd7;
    send_entry();

    settle_block();
    write_reg(CFG_TOTAL, TOTAL_RESET);
    write_reg(CFG_RESERVED, RESERVED_RESET);
    send_item(1'b1, 8'($urandom));
  endtask

  // The receiver stops for a long stretch while the sender streams without gaps, so the
  // result queue fills and the input stalls. The sender then waits for every result.
  task automatic test_full_stall();
    settle_block();
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    send_item(1'b1, 8'($urandom));
    hold_cycles = 400;
    repeat (6) begin
      random_entry();
      send_entry();
    end
    settle_block();
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  // Groups of random entries, each under fresh random settings. Most groups begin with a
  // start. Now and then an entry is cut short by a start.
  task automatic test_random_directory();
    int tot;
    int res;
    for (int grp = 0; grp < 4; grp++) begin
      settle_block();
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       tot = 0;
        1:       tot = $urandom_range(257, 511);
        2:       tot = 256;
        default: tot = $urandom_range(1, 256);
      endcase
      res = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                        : $urandom_range(0, (tot > 256) ? 256 : tot);
      write_reg(CFG_TOTAL, 9'(tot));
      write_reg(CFG_RESERVED, 9'(res));
      if ($urandom_range(0, 9) != 0) send_item(1'b1, 8'($urandom));
      for (int e = 0; e < 4; e++) begin
        if ($urandom_range(0, 19) == 0) begin
          random_entry();
          send_entry($urandom_range(1, 31));
          send_item(1'b1, 8'($urandom));
        end
        random_entry();
        send_entry();
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  // ------------------------------------------------------------------------------------
  // Sequence. Reset is held first, then the tests run in turn.
  // ------------------------------------------------------------------------------------
  initial begin : test_sequence
    total_reg    = TOTAL_RESET;
    reserved_reg = RESERVED_RESET;
    restart_map();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_entries();
    test_register_extremes();
    test_full_stall();
    test_random_directory();

    settle_block();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS cpm_directory_alloc_scanner_top");
    end else begin
      $display("FAIL cpm_directory_alloc_scanner_top");
    end
    $finish;
  end

endmodule
